### src/ses_pkg.sv
`timescale 1ns / 1ps

package ses_pkg;

   // field widths of the request and response words
   localparam int COORD_W = 16;
   localparam int VALUE_W = 64;

   // default sizing of the block
   localparam int DEFAULT_MAX_ENTRIES = 64;
   localparam int DEFAULT_INDEX_BITS  = 16;

   // smallest list that needs a sort pass
   localparam int MIN_SORT_COUNT = 2;

endpackage

### src/sparse_entry_sorter.sv
`timescale 1ns / 1ps

// Sparse entry sorter: collects coordinate-list entries (row, column, 64-bit value), one
// word per cycle, into an on-chip list of up to MAX_ENTRIES entries (entries beyond that
// are dropped, the final one too). The word flagged req_is_last starts a stable sort into
// (row, column) order; entries with equal coordinates keep their arrival order and values
// pass through unchanged. The sorted entries then leave on the rsp channel with
// rsp_out_last on the final one. Coordinates are kept as their low INDEX_BITS bits. The
// block takes no request word from the final word of a list until the last sorted entry
// sits in the output register. For a list of n entries the sort makes one bubble pass per
// list length from n down to 2, each pass one read-compare-write step per entry through
// the single list memory and its one comparator; each sorted entry is then read from the
// list memory and moved into the output register, waiting while the output is stalled.
module sparse_entry_sorter #(
   parameter int MAX_ENTRIES = ses_pkg::DEFAULT_MAX_ENTRIES,
   parameter int INDEX_BITS  = ses_pkg::DEFAULT_INDEX_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ses_pkg::COORD_W-1:0]  req_row_index,
   input  logic [ses_pkg::COORD_W-1:0]  req_col_index,
   input  logic [ses_pkg::VALUE_W-1:0]  req_entry_value,
   input  logic                         req_is_last,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ses_pkg::COORD_W-1:0]  rsp_out_row,
   output logic [ses_pkg::COORD_W-1:0]  rsp_out_col,
   output logic [ses_pkg::VALUE_W-1:0]  rsp_out_value,
   output logic                         rsp_out_last
);

   import ses_pkg::*;

   localparam int KEY_BITS  = (INDEX_BITS < COORD_W) ? INDEX_BITS : COORD_W;
   localparam int SORT_W    = 2 * KEY_BITS;
   localparam int ENTRY_W   = SORT_W + VALUE_W;
   localparam int ADDR_W    = $clog2(MAX_ENTRIES);
   localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] MIN_SORT  = CNT_W'(MIN_SORT_COUNT);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   typedef enum logic [2:0] {
      S_LOAD,
      S_PASS_START,
      S_FIRST,
      S_STEP,
      S_PASS_END,
      S_EMIT_RD,
      S_EMIT_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   pass_ff, pass_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [ENTRY_W-1:0] carry_ff, carry_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COORD_W-1:0] rsp_col_ff, rsp_col_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;

   // list memory: one write port, one registered read port
   logic [ENTRY_W-1:0] entry_mem_ff [MAX_ENTRIES];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               wr_en;

   logic [CNT_W-1:0]   idx_next;
   logic [CNT_W-1:0]   idx_prev;
   logic [CNT_W-1:0]   pass_prev;
   logic [CNT_W-1:0]   load_count;
   logic               list_full;
   logic               out_free;
   logic               carry_greater;

   assign idx_next   = idx_ff + CNT_ONE;
   assign idx_prev   = idx_ff - CNT_ONE;
   assign pass_prev  = pass_ff - CNT_ONE;
   assign list_full  = (count_ff >= MAX_COUNT);
   assign load_count = list_full ? count_ff : count_ff + CNT_ONE;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // the shared comparator: strict greater keeps equal keys in order
   assign carry_greater = carry_ff[ENTRY_W-1:VALUE_W] > rd_data_ff[ENTRY_W-1:VALUE_W];

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pass_in      = pass_ff;
      idx_in       = idx_ff;
      carry_in     = carry_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = carry_ff;
      rd_addr      = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (!list_full) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[ADDR_W-1:0];
                  wr_data  = {req_row_index[KEY_BITS-1:0], req_col_index[KEY_BITS-1:0],
                              req_entry_value};
                  count_in = load_count;
               end
               if (req_is_last) begin
                  pass_in = load_count;
                  idx_in  = '0;
                  if (load_count >= MIN_SORT) begin
                     state_in = S_PASS_START;
                  end else if (load_count == CNT_ONE) begin
                     state_in = S_EMIT_RD;
                  end
               end
            end
         end
         S_PASS_START: begin
            rd_addr  = '0;
            state_in = S_FIRST;
         end
         S_FIRST: begin
            // entry 0 becomes the carried element of this pass
            carry_in = rd_data_ff;
            rd_addr  = CNT_ONE[ADDR_W-1:0];
            idx_in   = CNT_ONE;
            state_in = S_STEP;
         end
         S_STEP: begin
            // write back the smaller one, carry the larger one onward
            wr_en   = 1'b1;
            wr_addr = idx_prev[ADDR_W-1:0];
            if (carry_greater) begin
               wr_data = rd_data_ff;
            end else begin
               wr_data  = carry_ff;
               carry_in = rd_data_ff;
            end
            rd_addr = idx_next[ADDR_W-1:0];
            idx_in  = idx_next;
            if (idx_next == pass_ff) begin
               state_in = S_PASS_END;
            end
         end
         S_PASS_END: begin
            // largest of the pass settles at its end
            wr_en   = 1'b1;
            wr_addr = pass_prev[ADDR_W-1:0];
            wr_data = carry_ff;
            pass_in = pass_prev;
            if (pass_prev < MIN_SORT) begin
               idx_in   = '0;
               state_in = S_EMIT_RD;
            end else begin
               state_in = S_PASS_START;
            end
         end
         S_EMIT_RD: begin
            rd_addr  = idx_ff[ADDR_W-1:0];
            state_in = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            rd_addr = idx_ff[ADDR_W-1:0];
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = COORD_W'(rd_data_ff[ENTRY_W-1 -: KEY_BITS]);
               rsp_col_in   = COORD_W'(rd_data_ff[VALUE_W +: KEY_BITS]);
               rsp_value_in = rd_data_ff[VALUE_W-1:0];
               rsp_last_in  = (idx_next == count_ff);
               if (idx_next == count_ff) begin
                  count_in = '0;
                  state_in = S_LOAD;
               end else begin
                  idx_in   = idx_next;
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pass_ff      <= pass_in;
      idx_ff       <= idx_in;
      carry_ff     <= carry_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // list memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign req_stall     = (state_ff != S_LOAD);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_last  = rsp_last_ff;

endmodule

### src/ses_checker.sv
`timescale 1ns / 1ps

module ses_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         req_is_last,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [ses_pkg::COORD_W-1:0]  rsp_out_row,
   input logic [ses_pkg::COORD_W-1:0]  rsp_out_col,
   input logic [ses_pkg::VALUE_W-1:0]  rsp_out_value,
   input logic                         rsp_out_last
);

   import ses_pkg::*;

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word valid right after reset");

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_row) && $stable(rsp_out_col)
         && $stable(rsp_out_value) && $stable(rsp_out_last))
      else $error("stalled response word changed");

   // the final word of a list closes the request side for sorting
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_is_last |=> req_stall)
      else $error("request taken right after the final word of a list");

   // no request is taken while a list is still being emitted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_last |-> req_stall)
      else $error("request side open in the middle of an emitted list");

endmodule

bind sparse_entry_sorter ses_checker u_ses_checker (.*);
